// File: sv/three_axis_step_mask_sequencer_top_assert.svh
// Assertion macros used by the step mask sequencer RTL.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef THREE_AXIS_STEP_MASK_SEQUENCER_TOP_ASSERT_SVH
`define THREE_AXIS_STEP_MASK_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAMS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TAMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tams_pkg.sv
// Shared types and constants of the three-axis step mask sequencer.
// No dependencies; every other file of the block but the assert header imports this package.
`default_nettype none

package tams_pkg;

   localparam int AXES          = 3;
   localparam int STEP_W        = 8;
   localparam int PAT_W         = 4;
   localparam int PHASE_W       = 2;
   localparam int PATTERNS_W    = PAT_W * (1 << PHASE_W);
   localparam int MAX_RANGE     = 64;
   localparam int MAG_W         = $clog2(MAX_RANGE + 2);
   localparam int ACC_W         = $clog2((MAX_RANGE + 1) * (MAX_RANGE + 1) + 1);
   localparam int MASK_W        = AXES * PAT_W;
   localparam int REQ_DATA_W    = ((AXES * STEP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((MASK_W + 7) / 8) * 8;
   localparam int MAX_SLOTS_DEF = 64;
   localparam int FIFO_DEPTH_DEF = 2;

   localparam logic [PATTERNS_W-1:0] PATTERNS_RESET = 16'h8421;

   // One classified move command as it waits between front and back.
   typedef struct packed {
      logic [AXES-1:0]            neg;
      logic [AXES-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]           big;
   } tams_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tams_fifo_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } tams_state_type;

endpackage

`default_nettype wire

// File: sv/three_axis_step_mask_sequencer_top.sv
// Top level of the three-axis step mask sequencer: front end, command queue,
// slot sequencer and the phase pattern register. Depends on tams_pkg.
//
// req_* carries one move item: three signed 8-bit step counts, clamped to
// MAX_SLOTS in magnitude. A move of all zeros is accepted and dropped.
// rsp_* carries one item per time slot. With L the largest clamped
// magnitude, a move yields L items and rsp_tlast marks the final one.
// csr_* writes the 16-bit phase pattern register (nibble i is the coil
// pattern of phase i). It is always ready; write it only while idle.
// An accepted item enters the queue and is loaded into the sequencer, which
// registers the first slot in its output register, then issues one slot per
// cycle while rsp_tready allows: a load step, then L slots. A two-entry command
// queue lets later moves be accepted while one is being issued.
// Reset is synchronous and active high: it empties the queue, idles the
// sequencer, clears the axis phases and loads pattern 0x8421. When
// rsp_tready is low the current slot holds in the output register and the
// sequencer pauses; req_tready drops only once the queue is full.
`default_nettype none

module three_axis_step_mask_sequencer_top #(
   parameter int MAX_SLOTS  = tams_pkg::MAX_SLOTS_DEF,
   parameter int FIFO_DEPTH = tams_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [7:0] steps_x, [15:8] steps_y, [23:16] steps_z
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [tams_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: [11:0] coil_mask, [15:12] zero; rsp_tlast is last_slot
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [tams_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   // csr_data: [15:0] phase_patterns
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tams_pkg::PATTERNS_W-1:0]  csr_data
);
   import tams_pkg::*;

   tams_cmd_type          push_cmd;
   tams_cmd_type          pop_cmd;
   tams_fifo_status_type  fifo_status;
   logic                  push;
   logic                  pop;
   logic [PATTERNS_W-1:0] patterns_ff, patterns_in;

   // The pattern register takes a write in any cycle.
   assign csr_ready   = 1'b1;
   assign patterns_in = (csr_valid && csr_ready) ? csr_data : patterns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         patterns_ff <= PATTERNS_RESET;
      end else begin
         patterns_ff <= patterns_in;
      end
   end

   // Classifies incoming moves and drops empty ones.
   tams_front #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .fifo_status (fifo_status),
      .push        (push),
      .cmd         (push_cmd)
   );

   // Decouples acceptance of moves from their slot-by-slot issue.
   tams_fifo #(
      .WIDTH ($bits(tams_cmd_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_cmd),
      .pop     (pop),
      .rd_data (pop_cmd),
      .status  (fifo_status)
   );

   // Issues the time slots of one move and owns the axis phases.
   tams_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .fifo_cmd    (pop_cmd),
      .pop         (pop),
      .patterns    (patterns_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: sv/tams_front.sv
// Front end: accepts move items, saturates magnitudes, finds the longest axis.
// Depends on tams_pkg; feeds the command queue.
`default_nettype none

module tams_front #(
   parameter int MAX_SLOTS = tams_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [tams_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire tams_pkg::tams_fifo_status_type   fifo_status,
   output logic                                  push,
   output tams_pkg::tams_cmd_type                cmd
);
   import tams_pkg::*;

   logic [AXES-1:0][STEP_W-1:0] abs_val;
   logic                        accept;

   assign req_tready = !fifo_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd = '0;
      for (int a = 0; a < AXES; a++) begin
         cmd.neg[a] = req_tdata[a*STEP_W + STEP_W - 1];
         // Two's complement of -128 gives 128, which the clamp catches below.
         abs_val[a] = cmd.neg[a] ? STEP_W'(-req_tdata[a*STEP_W +: STEP_W])
                                 : req_tdata[a*STEP_W +: STEP_W];
         if (abs_val[a] > STEP_W'(MAX_SLOTS)) begin
            cmd.mag[a] = MAG_W'(MAX_SLOTS);
         end else begin
            cmd.mag[a] = abs_val[a][MAG_W-1:0];
         end
         if (cmd.mag[a] > cmd.big) begin
            cmd.big = cmd.mag[a];
         end
      end
   end

   // A move with no steps on any axis produces nothing and is dropped here.
   assign push = accept && (cmd.big != '0);

endmodule

`default_nettype wire

// File: sv/tams_fifo.sv
// Short command queue between the front end and the slot sequencer.
// Depends on tams_pkg for the status struct.
`default_nettype none

module tams_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tams_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               wr_data,
   input  wire logic                           pop,
   output logic [WIDTH-1:0]                    rd_data,
   output tams_pkg::tams_fifo_status_type      status
);
   import tams_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/tams_back.sv
// Back end: walks the time slots of one move, steps the axis phases and
// registers one coil mask per slot. Depends on tams_pkg and the assert macros.
`default_nettype none
`include "three_axis_step_mask_sequencer_top_assert.svh"

module tams_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tams_pkg::tams_fifo_status_type   fifo_status,
   input  wire tams_pkg::tams_cmd_type           fifo_cmd,
   output logic                                  pop,
   input  wire logic [tams_pkg::PATTERNS_W-1:0]  patterns,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [tams_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);
   import tams_pkg::*;

   tams_state_type state_ff, state_in;
   tams_cmd_type   cmd_ff, cmd_in;

   logic [MAG_W-1:0]              slot_ff, slot_in;
   // Per axis: step n is due in slot k when slot_lo < n*L <= slot_hi,
   // with slot_lo = k*(m+1) and slot_hi = (k+1)*(m+1).
   logic [AXES-1:0][ACC_W-1:0]    acc_ff, acc_in;
   logic [AXES-1:0][ACC_W-1:0]    lo_ff, lo_in;
   logic [AXES-1:0][ACC_W-1:0]    hi_ff, hi_in;
   logic [AXES-1:0][MAG_W-1:0]    cnt_ff, cnt_in;
   logic [AXES-1:0][PHASE_W-1:0]  phase_ff, phase_in;
   logic [AXES-1:0][PHASE_W-1:0]  phase_next;
   logic [AXES-1:0]               step;
   logic [MASK_W-1:0]             mask_ff, mask_in, mask_next;
   logic                          last_ff, last_in;
   logic                          valid_ff, valid_in;
   logic                          load, fire, is_last;

   assign is_last = (slot_ff == cmd_ff.big - 1'b1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fire && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      load = 1'b0;
      fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: load = !fifo_status.empty;
         ST_RUN:  fire = !valid_ff || rsp_tready;
         default: begin
            load = 1'b0;
            fire = 1'b0;
         end
      endcase
   end

   assign pop = load;

   // Slot evaluation for all three axes.
   always_comb begin
      mask_next = '0;
      for (int a = 0; a < AXES; a++) begin
         step[a] = (cmd_ff.mag[a] != '0) && (cnt_ff[a] <= cmd_ff.mag[a]) &&
                   (acc_ff[a] <= hi_ff[a]) && (acc_ff[a] > lo_ff[a]);
         if (!step[a]) begin
            phase_next[a] = phase_ff[a];
         end else if (cmd_ff.neg[a]) begin
            phase_next[a] = phase_ff[a] - 1'b1;
         end else begin
            phase_next[a] = phase_ff[a] + 1'b1;
         end
         mask_next[a*PAT_W +: PAT_W] = patterns[phase_next[a]*PAT_W +: PAT_W];
      end
   end

   always_comb begin
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      mask_in  = mask_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         cmd_in  = fifo_cmd;
         slot_in = '0;
         for (int a = 0; a < AXES; a++) begin
            acc_in[a] = ACC_W'(fifo_cmd.big);
            lo_in[a]  = '0;
            hi_in[a]  = ACC_W'(fifo_cmd.mag[a]) + 1'b1;
            cnt_in[a] = MAG_W'(1);
         end
      end else if (fire) begin
         slot_in  = slot_ff + 1'b1;
         phase_in = phase_next;
         mask_in  = mask_next;
         last_in  = is_last;
         valid_in = 1'b1;
         for (int a = 0; a < AXES; a++) begin
            lo_in[a] = lo_ff[a] + ACC_W'(cmd_ff.mag[a]) + 1'b1;
            hi_in[a] = hi_ff[a] + ACC_W'(cmd_ff.mag[a]) + 1'b1;
            if (step[a]) begin
               acc_in[a] = acc_ff[a] + ACC_W'(cmd_ff.big);
               cnt_in[a] = cnt_ff[a] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      slot_ff <= slot_in;
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      cnt_ff  <= cnt_in;
      mask_ff <= mask_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(mask_ff);
   assign rsp_tlast  = last_ff;

   `TAMS_ASSERT_SAME(a_slot_in_range, state_ff == ST_RUN, slot_ff < cmd_ff.big,
      "slot counter ran past the move length")
   `TAMS_ASSERT_NEXT(a_last_ends_move, fire && is_last, state_ff == ST_IDLE,
      "sequencer kept running after the last slot")
   `TAMS_ASSERT_NEXT(a_phase_only_on_fire, !fire, $stable(phase_ff),
      "axis phase changed without a slot being issued")
   `TAMS_ASSERT_SAME(a_load_needs_cmd, load, !fifo_status.empty,
      "sequencer loaded a command from an empty queue")

endmodule

`default_nettype wire

// File: sim/three_axis_step_mask_sequencer_top_tb.sv
// Self-checking testbench for the three-axis step mask sequencer top level.
// Depends on tams_pkg and three_axis_step_mask_sequencer_top; it predicts every slot
// of every accepted move and checks the streamed coil masks in order.
`timescale 1ns / 100ps

module three_axis_step_mask_sequencer_top_tb;
   import tams_pkg::*;

   // The block is built with its default slot limit, so moves clamp there too.
   localparam int SLOT_LIMIT     = MAX_SLOTS_DEF;
   // Cycles to let pass after the last expected slot before touching the
   // register, so that any stray slot has time to show up and be caught.
   localparam int QUIET_CYCLES   = SLOT_LIMIT + 8;
   // Length of the one long stall of the result side.
   localparam int HOLD_CYCLES    = 300;
   // Idle chance of 13 percent on each side: the result side drops rsp_tready, the input side pauses before a move.
   localparam int IDLE_PERCENT   = 13;
   localparam int TIMEOUT_CYCLES = 500_000;
   localparam int MAX_PRINTED    = 100;

   // One expected time slot: the packed coil patterns and the end-of-move flag.
   typedef struct packed {
      logic [MASK_W-1:0] coil_mask;
      logic              last_slot;
   } coil_slot_type;

   // Scoreboard: keeps its own copy of the pattern register and the three
   // axis phases, expands every accepted move into its slots, and compares
   // each slot leaving the block with the oldest one still pending.
   class coil_slot_scoreboard;
      logic [PATTERNS_W-1:0] patterns;
      logic [PHASE_W-1:0]    phase [AXES];
      coil_slot_type         pending_slots [$];
      int                    errors;

      function new();
         patterns = PATTERNS_RESET;
         foreach (phase[a]) phase[a] = '0;
         errors = 0;
      endfunction

      function int pending();
         return pending_slots.size();
      endfunction

      // Expands one accepted move into the slots it must produce.
      function void note_move(logic [REQ_DATA_W-1:0] data);
         logic [STEP_W-1:0] raw;
         int unsigned       mag [AXES];
         bit                neg [AXES];
         int unsigned       taken [AXES];
         int unsigned       span;
         int unsigned       due;
         coil_slot_type     slot;
         span = 0;
         for (int a = 0; a < AXES; a++) begin
            raw = data[a*STEP_W +: STEP_W];
            neg[a] = raw[STEP_W-1];
            mag[a] = neg[a] ? (1 << STEP_W) - int'(raw) : int'(raw);
            if (mag[a] > SLOT_LIMIT) mag[a] = SLOT_LIMIT;
            taken[a] = 1;
            if (mag[a] > span) span = mag[a];
         end
         // An all-zero move is dropped without a slot.
         for (int unsigned k = 0; k < span; k++) begin
            slot.coil_mask = '0;
            for (int a = 0; a < AXES; a++) begin
               if (mag[a] != 0 && taken[a] <= mag[a]) begin
                  // Step n lands in the slot that is the exact integer ceiling
                  // of n*L/(m+1).
                  due = (taken[a] * span + mag[a]) / (mag[a] + 1);
                  if (due == k + 1) begin
                     taken[a]++;
                     phase[a] = neg[a] ? phase[a] - 1'b1 : phase[a] + 1'b1;
                  end
               end
               slot.coil_mask[a*PAT_W +: PAT_W] = patterns[phase[a]*PAT_W +: PAT_W];
            end
            slot.last_slot = (k + 1 == span);
            pending_slots.push_back(slot);
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_slot(logic [RSP_DATA_W-1:0] tdata, logic tlast);
         coil_slot_type want;
         if (pending_slots.size() == 0) begin
            report_mismatch($sformatf("slot with no move pending, coil_mask %h last %b",
                                      tdata[MASK_W-1:0], tlast));
            return;
         end
         want = pending_slots.pop_front();
         if (tdata[MASK_W-1:0] !== want.coil_mask)
            report_mismatch($sformatf("coil_mask %h, expected %h",
                                      tdata[MASK_W-1:0], want.coil_mask));
         if (tlast !== want.last_slot)
            report_mismatch($sformatf("last_slot %b, expected %b", tlast, want.last_slot));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [PATTERNS_W-1:0] csr_data   = '0;

   // Set by the stimulus: calm turns idling off on both sides, and
   // hold_request asks the result side for one long stall.
   bit calm         = 1'b0;
   bit hold_request = 1'b0;

   coil_slot_scoreboard sb = new();

   three_axis_step_mask_sequencer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Packs three step counts as req_tdata carries them, X in the low byte.
   function automatic logic [REQ_DATA_W-1:0] pack_move(int x, int y, int z);
      return {z[STEP_W-1:0], y[STEP_W-1:0], x[STEP_W-1:0]};
   endfunction

   // Random move content. Most moves stay within the legal range; some are
   // small, some use the full 8-bit code space to reach the clamp, a few are
   // all zero, and single axes are often idle.
   function automatic logic [REQ_DATA_W-1:0] random_move();
      int kind;
      int s [AXES];
      kind = $urandom_range(99);
      foreach (s[a]) begin
         if (kind < 5) s[a] = 0;
         else if (kind < 15) s[a] = $urandom_range(255);
         else if (kind < 35) s[a] = int'($urandom_range(16)) - 8;
         else s[a] = int'($urandom_range(2 * SLOT_LIMIT)) - SLOT_LIMIT;
         if (kind >= 5 && $urandom_range(9) == 0) s[a] = 0;
      end
      return pack_move(s[0], s[1], s[2]);
   endfunction

   // Offers one move and returns at the edge that accepts it, with
   // req_tvalid still high. The caller either offers the next move or lowers
   // req_tvalid in that same step, so valid is assigned only once per step.
   task automatic offer_move(logic [REQ_DATA_W-1:0] data);
      int gap;
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_move(data);
   endtask

   // Stops offering and waits until the block has gone idle: every slot in,
   // then a margin for any stray slot to appear.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Writes the phase pattern register; the model copy follows at the
   // accepting edge.
   task automatic write_patterns(logic [PATTERNS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.patterns = value;
   endtask

   // Result side: checks every accepted slot and decides rsp_tready for the
   // next cycle. The long stall is counted here, in this process, so the
   // stimulus can keep pushing moves until the queue fills and req_tready
   // drops.
   initial begin : slot_sink
      int hold_left;
      hold_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) sb.check_slot(rsp_tdata, rsp_tlast);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed moves under the reset patterns. The single-axis moves step
      // X, Y and Z in turn and then Y alone, so an idle Z must keep its own phase
      // rather than follow Y. Counts of 127, -128 and 65 must clamp to the slot
      // limit with their sign kept; 0x55 and 0xAA toggle the remaining bits.
      offer_move(pack_move(0, 0, 0));
      offer_move(pack_move(1, 0, 0));
      offer_move(pack_move(0, 1, 0));
      offer_move(pack_move(0, 0, 1));
      offer_move(pack_move(0, 3, 0));
      offer_move(pack_move(64, 0, 0));
      offer_move(pack_move(-64, 0, 0));
      offer_move(pack_move(0, 64, -64));
      offer_move(pack_move(127, 0, 0));
      offer_move(pack_move(-128, 0, 0));
      offer_move(pack_move(0, -128, 127));
      offer_move(pack_move(-1, -1, -1));
      offer_move(pack_move(1, 1, 1));
      offer_move(pack_move(64, 64, 64));
      offer_move(pack_move(-64, -64, -64));
      offer_move(pack_move(85, -86, 3));
      offer_move(pack_move(2, -5, 64));
      offer_move(pack_move(-3, 7, -11));
      offer_move(pack_move(65, -65, 0));
      offer_move(pack_move(0, 0, -2));
      offer_move(pack_move(0, 0, 0));
      offer_move(pack_move(5, -5, 1));

      // All coils on in every phase.
      wait_for_quiet();
      write_patterns('1);
      repeat (40) offer_move(random_move());

      // All coils off in every phase.
      wait_for_quiet();
      write_patterns('0);
      repeat (30) offer_move(random_move());

      // A random pattern set, first with no idling on either side.
      wait_for_quiet();
      write_patterns(PATTERNS_W'($urandom_range(65535)));
      calm = 1'b1;
      repeat (60) offer_move(random_move());
      calm = 1'b0;

      // The result side stalls for a long stretch while moves keep coming,
      // so the command queue fills and the input side backs up.
      hold_request = 1'b1;
      repeat (40) offer_move(random_move());

      // The sender pauses until every pending slot has come out.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (60) offer_move(random_move());

      // Back to the reset value, now written explicitly.
      wait_for_quiet();
      write_patterns(PATTERNS_RESET);
      repeat (60) offer_move(random_move());

      // Drain, then leave room for any stray slot to show up and be caught.
      wait_for_quiet();
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("TEST FAILED");
      $finish;
   end

endmodule
